// ===== rtl/core/tvfm_pkg.sv =====
package tvfm_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int POW_ITERATIONS = 16;

    localparam int FIELD_W    = 18;
    localparam int DENS_W     = 32;
    localparam int EXP_W      = 19;
    localparam int LEAD_W     = $clog2(DENS_W);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_THRESHOLD     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_ROOT_EXPONENT = 1'd1;

    localparam logic [DENS_W-1:0] THRESHOLD_RESET = 32'd19661;
    localparam logic [EXP_W-1:0]  EXPONENT_RESET  = 19'd65536;

    localparam int ONE_Q       = 1 << FRAC_BITS;
    localparam int EPS_SMALL   = (ONE_Q + 5000) / 10000;
    localparam int EPS_TINY    = (ONE_Q + 50000) / 100000;
    localparam int CORRUPT_LIM = (ONE_Q + 50) / 100;
    localparam int SAT_HI      = (2 * ONE_Q > (1 << FIELD_W) - 1) ? (1 << FIELD_W) - 1 : 2 * ONE_Q;

    // log/exp datapath
    localparam int LOG_W      = POW_ITERATIONS + 7;
    localparam int PROD_W     = LOG_W + EXP_W + 1;
    localparam int EXP_SHIFT  = POW_ITERATIONS + FRAC_BITS;
    localparam int N_W        = PROD_W - EXP_SHIFT;
    localparam int AMT_OFFSET = 31 - FRAC_BITS;
    localparam int POW_STAGES = 2 * POW_ITERATIONS + 3;

    // mixing datapath
    localparam int QUOT_W     = FRAC_BITS + 1;
    localparam int V_W        = FIELD_W + 2;
    localparam int S_W        = V_W + 1;
    localparam int BR_W       = V_W + 2;
    localparam int FOLD_W     = FIELD_W + QUOT_W;
    localparam int MIX_STAGES = 2 * QUOT_W + 5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef struct packed {
        logic [DENS_W-1:0]  track_density;
        logic [FIELD_W-1:0] white_fraction;
        logic [FIELD_W-1:0] gray_fraction;
        logic [FIELD_W-1:0] deep_gray_fraction;
        logic [FIELD_W-1:0] fluid_fraction;
    } in_req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] intra_axonal_out;
        logic [FIELD_W-1:0] extra_axonal_out;
        logic [FIELD_W-1:0] gray_out;
        logic [FIELD_W-1:0] fluid_out;
        logic               corrupt_flag;
    } out_res_t;

    typedef struct packed {
        logic [FIELD_W-1:0] wm;
        logic [FIELD_W-1:0] gm;
        logic [FIELD_W-1:0] dgm;
        logic [FIELD_W-1:0] csf;
    } tissue_t;

    typedef struct packed {
        tissue_t            tissue;
        logic [DENS_W-1:0]  mant;
        logic [LEAD_W-1:0]  lead;
        logic [EXP_W-1:0]   expo;
        logic               exp_zero;
        logic               dens_zero;
    } cls_req_t;

    typedef struct packed {
        tissue_t           tissue;
        logic [DENS_W-1:0] power;
    } pow_res_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bit_v;
        n     = n_in;
        res   = '0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n   = n - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // floor(2^(2^-(idx+1)) * 2^31) by repeated square roots
    function automatic logic [31:0] root_const(input int idx);
        logic [63:0] r;
        r = isqrt64(64'd1 << 63);
        for (int k = 1; k <= idx; k++) r = isqrt64(r << 31);
        return r[31:0];
    endfunction

endpackage

// ===== rtl/core/tvfm_front.sv =====
module tvfm_front import tvfm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  in_req_t          s_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [EXP_W-1:0] exponent,
    output cls_req_t         cls_data,
    output logic             cls_valid,
    input  logic             cls_ready
);

    cls_req_t cls_reg;
    cls_req_t cls_next;
    logic     cls_valid_reg;
    logic [LEAD_W-1:0] lead;

    assign s_ready   = !cls_valid_reg || cls_ready;
    assign cls_data  = cls_reg;
    assign cls_valid = cls_valid_reg;

    // leading-one position, highest set bit wins
    always_comb begin
        lead = '0;
        for (int k = 0; k < DENS_W; k++) begin
            if (s_data.track_density[k]) lead = LEAD_W'(k);
        end
    end

    always_comb begin
        cls_next.tissue.wm  = s_data.white_fraction;
        cls_next.tissue.gm  = s_data.gray_fraction;
        cls_next.tissue.dgm = s_data.deep_gray_fraction;
        cls_next.tissue.csf = s_data.fluid_fraction;
        cls_next.mant       = s_data.track_density << (LEAD_W'(DENS_W - 1) - lead);
        cls_next.lead       = lead;
        cls_next.expo       = exponent;
        cls_next.exp_zero   = (exponent == '0);
        cls_next.dens_zero  = (s_data.track_density == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cls_valid_reg <= 1'b0;
        end else if (s_ready) begin
            cls_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cls_reg <= cls_next;
        end
    end

endmodule

// ===== rtl/core/tvfm_queue.sv =====
module tvfm_queue import tvfm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  cls_req_t in_data,
    input  logic     in_valid,
    output logic     in_ready,
    output cls_req_t out_data,
    output logic     out_valid,
    input  logic     out_ready
);

    cls_req_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_wr;
    logic              do_rd;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd) count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) mem_reg[wr_ptr_reg] <= in_data;
    end

endmodule

// ===== rtl/core/tvfm_pow.sv =====
module tvfm_pow import tvfm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  cls_req_t in_data,
    input  logic     in_valid,
    output pow_res_t out_data,
    output logic     out_valid
);

    typedef struct packed {
        tissue_t                   tissue;
        logic [DENS_W-1:0]         mant;
        logic [POW_ITERATIONS-1:0] fb;
        logic [LEAD_W-1:0]         lead;
        logic [EXP_W-1:0]          expo;
        logic                      exp_zero;
        logic                      dens_zero;
    } lg_t;

    typedef struct packed {
        tissue_t                   tissue;
        logic [31:0]               r;
        logic [POW_ITERATIONS-1:0] fb;
        logic signed [N_W-1:0]     n;
        logic                      exp_zero;
        logic                      dens_zero;
    } ex_t;

    lg_t lg_reg  [POW_ITERATIONS+1];
    lg_t lg_next [POW_ITERATIONS];
    ex_t ex_reg  [POW_ITERATIONS+1];
    ex_t ex_next [POW_ITERATIONS+1];
    pow_res_t pw_reg;
    pow_res_t pw_next;
    logic [POW_STAGES-1:0] v_reg;

    logic signed [LOG_W-1:0]  l_val;
    logic signed [PROD_W-1:0] p_val;
    logic signed [N_W:0]      amt;
    logic signed [N_W:0]      neg_amt;

    assign out_data  = pw_reg;
    assign out_valid = v_reg[POW_STAGES-1];

    // log2 mantissa: one squaring per stage, one fraction bit each
    for (genvar gi = 0; gi < POW_ITERATIONS; gi++) begin : g_log
        logic [63:0] sq;
        assign sq = 64'(lg_reg[gi].mant) * 64'(lg_reg[gi].mant);
        always_comb begin
            lg_next[gi]      = lg_reg[gi];
            lg_next[gi].fb   = {lg_reg[gi].fb[POW_ITERATIONS-2:0], sq[63]};
            lg_next[gi].mant = sq[63] ? sq[63:32] : sq[62:31];
        end
    end

    // log times exponent, split into floor integer and fraction
    always_comb begin
        l_val = ((LOG_W'($signed({1'b0, lg_reg[POW_ITERATIONS].lead})) - LOG_W'(FRAC_BITS))
                 <<< POW_ITERATIONS) + LOG_W'(lg_reg[POW_ITERATIONS].fb);
        p_val = PROD_W'(l_val) * PROD_W'($signed({1'b0, lg_reg[POW_ITERATIONS].expo}));
        ex_next[0].tissue    = lg_reg[POW_ITERATIONS].tissue;
        ex_next[0].r         = 32'h8000_0000;
        ex_next[0].fb        = p_val[EXP_SHIFT-1:FRAC_BITS];
        ex_next[0].n         = p_val[PROD_W-1:EXP_SHIFT];
        ex_next[0].exp_zero  = lg_reg[POW_ITERATIONS].exp_zero;
        ex_next[0].dens_zero = lg_reg[POW_ITERATIONS].dens_zero;
    end

    // exp2: one root constant per stage, rounded half up
    for (genvar gi = 0; gi < POW_ITERATIONS; gi++) begin : g_exp
        localparam logic [31:0] ROOT = root_const(gi);
        logic [63:0] pr;
        assign pr = 64'(ex_reg[gi].r) * 64'(ROOT) + 64'(32'h4000_0000);
        always_comb begin
            ex_next[gi+1] = ex_reg[gi];
            if (ex_reg[gi].fb[POW_ITERATIONS-1-gi]) ex_next[gi+1].r = pr[62:31];
        end
    end

    // final scale by 2^n, saturate, special cases
    always_comb begin
        amt     = (N_W+1)'(ex_reg[POW_ITERATIONS].n) - (N_W+1)'(AMT_OFFSET);
        neg_amt = -amt;
        pw_next.tissue = ex_reg[POW_ITERATIONS].tissue;
        priority if (ex_reg[POW_ITERATIONS].exp_zero) begin
            pw_next.power = DENS_W'(ONE_Q);
        end else if (ex_reg[POW_ITERATIONS].dens_zero) begin
            pw_next.power = '0;
        end else if (amt > 0) begin
            pw_next.power = '1;
        end else if (amt == 0) begin
            pw_next.power = ex_reg[POW_ITERATIONS].r;
        end else if (amt < -31) begin
            pw_next.power = '0;
        end else begin
            pw_next.power = ex_reg[POW_ITERATIONS].r >> neg_amt[4:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[POW_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lg_reg[0].tissue    <= in_data.tissue;
            lg_reg[0].mant      <= in_data.mant;
            lg_reg[0].fb        <= '0;
            lg_reg[0].lead      <= in_data.lead;
            lg_reg[0].expo      <= in_data.expo;
            lg_reg[0].exp_zero  <= in_data.exp_zero;
            lg_reg[0].dens_zero <= in_data.dens_zero;
            for (int k = 0; k < POW_ITERATIONS; k++) lg_reg[k+1] <= lg_next[k];
            for (int k = 0; k <= POW_ITERATIONS; k++) ex_reg[k] <= ex_next[k];
            pw_reg <= pw_next;
        end
    end

endmodule

// ===== rtl/core/tvfm_mix.sv =====
module tvfm_mix import tvfm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic [DENS_W-1:0] threshold,
    input  pow_res_t          in_data,
    input  logic              in_valid,
    output out_res_t          out_data,
    output logic              out_valid
);

    typedef struct packed {
        tissue_t           tissue;
        logic [DENS_W-1:0] rem;
        logic [QUOT_W-1:0] q;
    } dv_t;

    typedef struct packed {
        logic [FIELD_W-1:0] wm;
        logic [V_W-1:0]     gm;
        logic [FIELD_W-1:0] csf;
        logic [QUOT_W-1:0]  intra;
    } fd_t;

    typedef struct packed {
        logic [V_W-1:0]    gm;
        logic [V_W-1:0]    csf;
        logic [QUOT_W-1:0] intra;
        logic [QUOT_W-1:0] inter;
        logic              corrupt;
    } br_t;

    // lanes: 0 intra, 1 extra, 2 gray, 3 fluid
    typedef struct packed {
        logic [3:0][V_W-1:0]    val;
        logic [3:0][S_W-1:0]    rem;
        logic [3:0][QUOT_W-1:0] q;
        logic [S_W-1:0]         sum;
        logic                   norm;
        logic                   corrupt;
    } nd_t;

    dv_t dv_reg  [QUOT_W+1];
    dv_t dv_next [QUOT_W+1];
    fd_t fd_reg;
    fd_t fd_next;
    br_t br_reg;
    br_t br_next;
    nd_t nd_reg  [QUOT_W+1];
    nd_t nd_next [QUOT_W+1];
    out_res_t out_reg;
    out_res_t out_next;
    logic [MIX_STAGES-1:0] v_reg;

    logic [QUOT_W-1:0]       intra_w;
    logic [FOLD_W-1:0]       fold_prod;
    logic signed [BR_W-1:0]  csf_s;
    logic signed [BR_W-1:0]  gm_s;
    logic signed [BR_W-1:0]  wm_s;
    logic signed [BR_W-1:0]  intra_s;
    logic signed [BR_W-1:0]  inter_s;
    logic signed [BR_W-1:0]  sum_s;
    logic [S_W-1:0]          tot;
    logic [3:0][V_W-1:0]     lane_v;

    assign out_data  = out_reg;
    assign out_valid = v_reg[MIX_STAGES-1];

    function automatic logic [FIELD_W-1:0] sat_out(input logic [V_W-1:0] x);
        return (x > V_W'(SAT_HI)) ? FIELD_W'(SAT_HI) : x[FIELD_W-1:0];
    endfunction

    function automatic logic [V_W-1:0] pick(input int l, input nd_t nd);
        return nd.norm ? V_W'(nd.q[l]) : nd.val[l];
    endfunction

    // clamp at threshold
    always_comb begin
        dv_next[0].tissue = in_data.tissue;
        dv_next[0].rem    = (in_data.power > threshold) ? threshold : in_data.power;
        dv_next[0].q      = '0;
    end

    // power * ONE / threshold, one quotient bit per stage
    for (genvar gi = 0; gi < QUOT_W; gi++) begin : g_tdiv
        logic [DENS_W:0] cand;
        logic            ge;
        assign cand = (gi == 0) ? {1'b0, dv_reg[gi].rem} : {dv_reg[gi].rem, 1'b0};
        assign ge   = (cand >= {1'b0, threshold});
        always_comb begin
            dv_next[gi+1]        = dv_reg[gi];
            dv_next[gi+1].q      = {dv_reg[gi].q[QUOT_W-2:0], ge};
            dv_next[gi+1].rem    = ge ? DENS_W'(cand - {1'b0, threshold}) : cand[DENS_W-1:0];
        end
    end

    // deep gray fold
    always_comb begin
        intra_w   = (threshold == '0) ? '0 : dv_reg[QUOT_W].q;
        fold_prod = FOLD_W'(dv_reg[QUOT_W].tissue.dgm) * FOLD_W'(QUOT_W'(ONE_Q) - intra_w);
        fd_next.wm    = dv_reg[QUOT_W].tissue.wm;
        fd_next.csf   = dv_reg[QUOT_W].tissue.csf;
        fd_next.intra = intra_w;
        fd_next.gm    = V_W'(dv_reg[QUOT_W].tissue.gm) + V_W'(fold_prod >> FRAC_BITS);
    end

    // white matter reassignment or fill / cut back
    always_comb begin
        csf_s   = BR_W'(fd_reg.csf);
        gm_s    = BR_W'(fd_reg.gm);
        wm_s    = BR_W'(fd_reg.wm);
        intra_s = BR_W'(fd_reg.intra);
        inter_s = '0;
        sum_s   = csf_s + gm_s + intra_s;
        br_next.corrupt = 1'b0;
        if (intra_s < BR_W'(EPS_SMALL) && wm_s > BR_W'(EPS_SMALL)) begin
            priority if (csf_s + gm_s == '0) begin
                gm_s = gm_s + wm_s;
            end else if (csf_s > gm_s) begin
                csf_s = csf_s + wm_s;
            end else begin
                gm_s = gm_s + wm_s;
            end
        end else if (intra_s > BR_W'(EPS_SMALL)) begin
            if (sum_s < BR_W'(ONE_Q)) begin
                inter_s = BR_W'(ONE_Q) - sum_s;
            end else if (sum_s > BR_W'(ONE_Q)) begin
                intra_s = BR_W'(ONE_Q) - (csf_s + gm_s);
            end
            if (intra_s < BR_W'(-CORRUPT_LIM)) br_next.corrupt = 1'b1;
            if (intra_s < 0) intra_s = '0;
        end
        br_next.gm    = V_W'(gm_s);
        br_next.csf   = V_W'(csf_s);
        br_next.intra = QUOT_W'(intra_s);
        br_next.inter = QUOT_W'(inter_s);
    end

    // total and renormalize decision
    always_comb begin
        lane_v[0] = V_W'(br_reg.intra);
        lane_v[1] = V_W'(br_reg.inter);
        lane_v[2] = br_reg.gm;
        lane_v[3] = br_reg.csf;
        tot = S_W'(lane_v[0]) + S_W'(lane_v[1]) + S_W'(lane_v[2]) + S_W'(lane_v[3]);
        nd_next[0].val     = lane_v;
        nd_next[0].sum     = tot;
        nd_next[0].corrupt = br_reg.corrupt;
        nd_next[0].norm    = (tot > S_W'(ONE_Q + EPS_TINY) || tot < S_W'(ONE_Q - EPS_TINY))
                             && tot > S_W'(EPS_SMALL);
        for (int l = 0; l < 4; l++) begin
            nd_next[0].rem[l] = S_W'(lane_v[l]);
            nd_next[0].q[l]   = '0;
        end
    end

    // four lanes of x * ONE / sum
    for (genvar gi = 0; gi < QUOT_W; gi++) begin : g_ndiv
        for (genvar gl = 0; gl < 4; gl++) begin : g_lane
            logic [S_W:0] cand;
            logic         ge;
            assign cand = (gi == 0) ? {1'b0, nd_reg[gi].rem[gl]} : {nd_reg[gi].rem[gl], 1'b0};
            assign ge   = (cand >= {1'b0, nd_reg[gi].sum});
            always_comb begin
                nd_next[gi+1].q[gl]   = {nd_reg[gi].q[gl][QUOT_W-2:0], ge};
                nd_next[gi+1].rem[gl] = ge ? S_W'(cand - {1'b0, nd_reg[gi].sum}) : cand[S_W-1:0];
            end
        end
        always_comb begin
            nd_next[gi+1].val     = nd_reg[gi].val;
            nd_next[gi+1].sum     = nd_reg[gi].sum;
            nd_next[gi+1].norm    = nd_reg[gi].norm;
            nd_next[gi+1].corrupt = nd_reg[gi].corrupt;
        end
    end

    // select and saturate
    always_comb begin
        out_next.intra_axonal_out = sat_out(pick(0, nd_reg[QUOT_W]));
        out_next.extra_axonal_out = sat_out(pick(1, nd_reg[QUOT_W]));
        out_next.gray_out         = sat_out(pick(2, nd_reg[QUOT_W]));
        out_next.fluid_out        = sat_out(pick(3, nd_reg[QUOT_W]));
        out_next.corrupt_flag     = nd_reg[QUOT_W].corrupt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[MIX_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= QUOT_W; k++) dv_reg[k] <= dv_next[k];
            fd_reg <= fd_next;
            br_reg <= br_next;
            for (int k = 0; k <= QUOT_W; k++) nd_reg[k] <= nd_next[k];
            out_reg <= out_next;
        end
    end

endmodule

// ===== rtl/core/tissue_volume_fraction_mixer_core.sv =====
// Path from request accept to result valid: front register, queue, power pipeline, then
// mixing pipeline; the back end holds while the output is stalled.
// Throughput: one request per cycle while the output is not stalled; every unit (log
// squarers, exp2 root multipliers, threshold and renormalize dividers) is fully pipelined,
// one bit or one step a stage. Reset: aresetn synchronous active low; clears pipeline valids
// and the queue, loads density_threshold = 19661 and inverse_root_exponent = 65536.
module tissue_volume_fraction_mixer_core import tvfm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_req_t               s_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    output out_res_t              m_data,
    output logic                  m_valid,
    input  logic                  m_ready
);

    logic [DENS_W-1:0] threshold_reg;
    logic [EXP_W-1:0]  exponent_reg;

    cls_req_t front_data;
    logic     front_valid;
    logic     front_ready;
    cls_req_t queue_data;
    logic     queue_valid;
    pow_res_t pow_data;
    logic     pow_valid;
    logic     back_en;

    // Back end is one lockstep pipeline; it advances whenever the output slot
    // is free or being drained. The front keeps taking requests into the queue
    // while the back end is stalled, until the queue is full.
    assign back_en = !m_valid || m_ready;

    // Config registers; the user must write them only while no request is in flight (not enforced here).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            exponent_reg  <= EXPONENT_RESET;
        end else if (cfg_write_en) begin
            unique case (cfg_index)
                CFG_DENSITY_THRESHOLD:     threshold_reg <= cfg_data[DENS_W-1:0];
                CFG_INVERSE_ROOT_EXPONENT: exponent_reg  <= cfg_data[EXP_W-1:0];
            endcase
        end
    end

    // Front: leading-one normalize of the density, special-case flags.
    tvfm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .exponent  (exponent_reg),
        .cls_data  (front_data),
        .cls_valid (front_valid),
        .cls_ready (front_ready)
    );

    // Short decoupling queue between front and back.
    tvfm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (front_data),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_data  (queue_data),
        .out_valid (queue_valid),
        .out_ready (back_en)
    );

    // Back, part one: density ^ exponent via log2 / exp2.
    tvfm_pow u_pow (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (back_en),
        .in_data   (queue_data),
        .in_valid  (queue_valid),
        .out_data  (pow_data),
        .out_valid (pow_valid)
    );

    // Back, part two: threshold divide, tissue mixing, renormalize, saturate.
    tvfm_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (back_en),
        .threshold (threshold_reg),
        .in_data   (pow_data),
        .in_valid  (pow_valid),
        .out_data  (m_data),
        .out_valid (m_valid)
    );

endmodule

// ===== tb/sv/tvfm_checker.sv =====
module tvfm_checker import tvfm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_req_t               s_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  out_res_t              m_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    output int                    fail_count,
    output int                    pending_count,
    output int                    result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [DENS_W-1:0] thr_q;
    logic [EXP_W-1:0]  expo_q;
    logic [63:0]       root_lut[32];
    out_res_t          mix_expected[$];

    function automatic logic [63:0] sqrt_floor(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] cand;
        res = '0;
        for (int b = 31; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            if (cand * cand <= n) res = cand;
        end
        return res;
    endfunction

    initial begin
        root_lut[0] = sqrt_floor(64'd1 << 63);
        for (int i = 1; i < 32; i++) root_lut[i] = sqrt_floor(root_lut[i-1] << 31);
    end

    // density^exponent via squaring log2 and root-product exp2
    function automatic logic [31:0] density_pow(input logic [31:0] d, input logic [18:0] e);
        int          p;
        logic [63:0] m, fr, fb, r, v, mag, nq;
        longint      lg, pr, n, amt;
        if (e == 0) return ONE_Q;
        if (d == 0) return 0;
        p = 31;
        while (!d[p]) p--;
        m  = 64'(d) << (31 - p);
        fr = 0;
        for (int i = 0; i < POW_ITERATIONS; i++) begin
            m  = (m * m) >> 31;
            fr = fr << 1;
            if (m >= (64'd1 << 32)) begin
                m  = m >> 1;
                fr = fr | 64'd1;
            end
        end
        lg = longint'(p - FRAC_BITS) * (longint'(1) << POW_ITERATIONS) + longint'(fr);
        pr = lg * longint'(e);
        if (pr >= 0) begin
            n  = pr >>> EXP_SHIFT;
            fr = 64'(pr) & ((64'd1 << EXP_SHIFT) - 1);
        end else begin
            mag = 64'(-pr);
            nq  = mag >> EXP_SHIFT;
            fr  = mag & ((64'd1 << EXP_SHIFT) - 1);
            if (fr == 0) begin
                n = -longint'(nq);
            end else begin
                n  = -longint'(nq) - 1;
                fr = (64'd1 << EXP_SHIFT) - fr;
            end
        end
        fb = fr >> FRAC_BITS;
        r  = 64'd1 << 31;
        for (int i = 1; i <= POW_ITERATIONS; i++)
            if (fb[POW_ITERATIONS - i]) r = (r * root_lut[i-1] + (64'd1 << 30)) >> 31;
        amt = n + FRAC_BITS - 31;
        if (amt >= 32) return 32'hFFFF_FFFF;
        if (amt >= 0) v = r << amt;
        else if (amt <= -40) v = 0;
        else v = r >> (-amt);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [FIELD_W-1:0] clip_frac(input longint x);
        if (x < 0) return '0;
        if (x > SAT_HI) return FIELD_W'(SAT_HI);
        return x[FIELD_W-1:0];
    endfunction

    function automatic out_res_t mix_voxel(input in_req_t q);
        logic [63:0] pw;
        longint      wm, gm, dgm, csf, intra, inter, s;
        out_res_t    o;
        o     = '0;
        wm    = longint'(q.white_fraction);
        gm    = longint'(q.gray_fraction);
        dgm   = longint'(q.deep_gray_fraction);
        csf   = longint'(q.fluid_fraction);
        intra = 0;
        inter = 0;
        pw    = 64'(density_pow(q.track_density, expo_q));
        if (thr_q != 0) begin
            if (pw > 64'(thr_q)) pw = 64'(thr_q);
            intra = longint'((pw << FRAC_BITS) / 64'(thr_q));
        end
        if (dgm > 0) gm += (dgm * (ONE_Q - intra)) / ONE_Q;
        if (intra < EPS_SMALL && wm > EPS_SMALL) begin
            if (csf + gm == 0) gm += wm;
            else if (csf > gm) csf += wm;
            else gm += wm;
        end else if (intra > EPS_SMALL) begin
            s = csf + gm + intra;
            if (s < ONE_Q) inter = ONE_Q - s;
            else if (s > ONE_Q) intra = ONE_Q - (csf + gm);
            if (intra < -CORRUPT_LIM) o.corrupt_flag = 1'b1;
            if (intra < 0) intra = 0;
        end
        s = csf + gm + intra + inter;
        if ((s - ONE_Q > EPS_TINY || ONE_Q - s > EPS_TINY) && s > EPS_SMALL) begin
            csf   = (csf * ONE_Q) / s;
            gm    = (gm * ONE_Q) / s;
            intra = (intra * ONE_Q) / s;
            inter = (inter * ONE_Q) / s;
        end
        o.intra_axonal_out = clip_frac(intra);
        o.extra_axonal_out = clip_frac(inter);
        o.gray_out         = clip_frac(gm);
        o.fluid_out        = clip_frac(csf);
        return o;
    endfunction

    assign pending_count = mix_expected.size();

    always @(posedge aclk) begin
        out_res_t want;
        if (!aresetn) begin
            thr_q  <= THRESHOLD_RESET;
            expo_q <= EXPONENT_RESET;
            mix_expected.delete();
            fail_count   <= 0;
            result_count <= 0;
        end else begin
            if (cfg_write_en) begin
                if (cfg_index == CFG_DENSITY_THRESHOLD) thr_q <= cfg_data;
                else if (cfg_index == CFG_INVERSE_ROOT_EXPONENT) expo_q <= cfg_data[EXP_W-1:0];
            end
            if (s_valid && s_ready) mix_expected.push_back(mix_voxel(s_data));
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (mix_expected.size() == 0) begin
                    $error("result with nothing expected: %h", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = mix_expected.pop_front();
                    if (want != m_data) fail_count <= fail_count + 1;
                    if (want.intra_axonal_out != m_data.intra_axonal_out)
                        $error("intra_axonal_out exp %0d got %0d",
                               want.intra_axonal_out, m_data.intra_axonal_out);
                    if (want.extra_axonal_out != m_data.extra_axonal_out)
                        $error("extra_axonal_out exp %0d got %0d",
                               want.extra_axonal_out, m_data.extra_axonal_out);
                    if (want.gray_out != m_data.gray_out)
                        $error("gray_out exp %0d got %0d", want.gray_out, m_data.gray_out);
                    if (want.fluid_out != m_data.fluid_out)
                        $error("fluid_out exp %0d got %0d", want.fluid_out, m_data.fluid_out);
                    if (want.corrupt_flag != m_data.corrupt_flag)
                        $error("corrupt_flag exp %0d got %0d",
                               want.corrupt_flag, m_data.corrupt_flag);
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import tvfm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;  // cycles with no handshake before giving up
    localparam int DRAIN_WAIT  = 100;   // extra settle time after the last expected result

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    in_req_t               s_data;
    logic                  s_valid;
    logic                  s_ready;
    out_res_t              m_data;
    logic                  m_valid;
    logic                  m_ready;

    int fail_count, pending_count, result_count;
    int send_idle_pct, recv_stall_pct;
    bit hold_off_req;
    int sent_count;

    tissue_volume_fraction_mixer_core uut (.*);

    tvfm_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver: random stalls, plus one long hold-off so the pipe backs up
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            m_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: count cycles without any handshake
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_voxel(input in_req_t q);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= q;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    // only between phases: drain, then let the pipe settle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge aclk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic logic [FIELD_W-1:0] rand_frac();
        case ($urandom_range(9))
            0:       return FIELD_W'($urandom);                 // includes out-of-range values
            1:       return FIELD_W'($urandom_range(EPS_SMALL));
            2:       return '0;
            default: return FIELD_W'($urandom_range(ONE_Q));
        endcase
    endfunction

    function automatic in_req_t rand_voxel(input logic [31:0] thr);
        in_req_t q;
        int      share;
        case ($urandom_range(5))
            0:       q.track_density = $urandom;
            1:       q.track_density = $urandom_range(255);
            2:       q.track_density = '0;
            default: q.track_density = (thr == 0) ? $urandom : $urandom_range(thr * 2 + 1);
        endcase
        if ($urandom_range(3) != 0) begin
            // well-formed mixture summing to about one
            share = ONE_Q;
            q.white_fraction     = FIELD_W'($urandom_range(share));
            share -= int'(q.white_fraction);
            q.gray_fraction      = FIELD_W'($urandom_range(share));
            share -= int'(q.gray_fraction);
            q.deep_gray_fraction = FIELD_W'($urandom_range(share));
            share -= int'(q.deep_gray_fraction);
            q.fluid_fraction     = FIELD_W'(share);
        end else begin
            q.white_fraction     = rand_frac();
            q.gray_fraction      = rand_frac();
            q.deep_gray_fraction = rand_frac();
            q.fluid_fraction     = rand_frac();
        end
        return q;
    endfunction

    function automatic in_req_t voxel(input logic [31:0] d, input int w, input int g,
                                      input int dg, input int f);
        in_req_t q;
        q.track_density      = d;
        q.white_fraction     = FIELD_W'(w);
        q.gray_fraction      = FIELD_W'(g);
        q.deep_gray_fraction = FIELD_W'(dg);
        q.fluid_fraction     = FIELD_W'(f);
        return q;
    endfunction

    initial begin
        logic [31:0] thr_set[8];
        logic [31:0] exp_set[8];
        cfg_write_en   = 1'b0;
        cfg_index      = CFG_DENSITY_THRESHOLD;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_data         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b0;
        sent_count     = 0;
        aresetn        = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // threshold extremes including zero; exponent extremes including zero
        thr_set = '{THRESHOLD_RESET, 32'hFFFF_FFFF, 32'd1, 32'd65536, 32'd0,
                    $urandom, $urandom_range(2000000), 32'd19661};
        exp_set = '{EXPONENT_RESET, 32'd262144, 32'd4096, 32'd65536, 32'd0,
                    $urandom_range(262144, 4096), 32'h7FFFF, $urandom_range(262144, 4096)};

        // directed: run at reset values first
        send_voxel(voxel(0, 0, 0, 0, 0));
        send_voxel(voxel(32'hFFFF_FFFF, ONE_Q, 0, 0, 0));
        send_voxel(voxel(32'hFFFF_FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF));
        send_voxel(voxel(0, ONE_Q, 0, 0, 0));          // white matter with no gray/fluid
        send_voxel(voxel(0, ONE_Q / 2, 100, 0, ONE_Q / 2)); // white goes to fluid
        send_voxel(voxel(0, ONE_Q / 2, ONE_Q / 2, 0, 100)); // white goes to gray
        send_voxel(voxel(19661, 0, ONE_Q / 4, 0, ONE_Q / 4)); // intra cut back to fill the remainder
        send_voxel(voxel(19661, 0, ONE_Q, ONE_Q, ONE_Q));     // cut back, corrupt
        send_voxel(voxel(19661, 0, ONE_Q / 2, 0, ONE_Q / 2 + 100)); // slight cut back
        send_voxel(voxel(1, ONE_Q, 0, ONE_Q, 0));
        send_voxel(voxel(32'h0001_0000, 0, 2 * ONE_Q, 0, 0));
        send_voxel(voxel(32'h8000_0000, 5, 5, 5, 5));
        send_voxel(voxel(19661 / 2, 0, ONE_Q / 2, ONE_Q / 2, 0));

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_DENSITY_THRESHOLD, thr_set[ph]);
            write_reg(CFG_INVERSE_ROOT_EXPONENT, exp_set[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            if (ph == 3) begin
                // intra fraction lands on the small-epsilon edge with a unit exponent
                send_voxel(voxel(7, ONE_Q / 2, ONE_Q / 4, 0, ONE_Q / 4));
                send_voxel(voxel(8, ONE_Q / 2, ONE_Q / 4, 0, ONE_Q / 4));
            end
            if (ph == 0) hold_off_req = 1'b1;
            for (int n = 0; n < 215; n++) send_voxel(rand_voxel(thr_set[ph]));
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Sent %0d voxels over 8 threshold/exponent settings, %0d results checked",
                 sent_count, result_count);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
